// ----- hw/rtl/scfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

	// Largest parameter count a command may announce
	localparam int MAX_PARAMS = 16;

	// Job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Byte positions inside a command frame
	localparam logic [2:0] IDX_HDR0 = 3'd0;
	localparam logic [2:0] IDX_HDR1 = 3'd1;
	localparam logic [2:0] IDX_ID   = 3'd2;
	localparam logic [2:0] IDX_LEN  = 3'd3;
	localparam logic [2:0] IDX_INS  = 3'd4;
	localparam logic [2:0] IDX_ADDR = 3'd5;
	localparam logic [2:0] IDX_CSUM = 3'd6;

	localparam logic KIND_CMD   = 1'b0;
	localparam logic KIND_PARAM = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		JOB_CMD   = 2'd0,
		JOB_PARAM = 2'd1,
		JOB_ERR   = 2'd2
	} job_kind_t;

	// One classified item: everything the back end needs to emit its bytes
	typedef struct packed {
		job_kind_t  jtype;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] hdr;
		logic [7:0] csum;
		logic       with_csum;
		status_t    status;
	} job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scfr_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface scfr_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] device_id;
	logic [7:0] instruction_code;
	logic [7:0] register_address;
	logic [4:0] param_count;
	logic [7:0] param_byte;

	modport source (output valid, kind, device_id, instruction_code, register_address,
		param_count, param_byte, input ready);
	modport sink (input valid, kind, device_id, instruction_code, register_address,
		param_count, param_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scfr_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface scfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic [1:0] status;

	modport source (output valid, out_byte, frame_end, status, input ready);
	modport sink (input valid, out_byte, frame_end, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scfr_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface scfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;

	modport source (output valid, header_byte, input ready);
	modport sink (input valid, header_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfr_front
	import scfr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	scfr_item_if.sink   item,
	scfr_cfg_if.sink    cfg,
	output logic        push_valid,
	output job_t        push_job,
	input  wire logic   push_ready
);

	logic       awaiting_q;
	logic [4:0] left_q;
	logic [7:0] sum_q;
	logic [7:0] hdr_q;

	logic       awaiting_d;
	logic [4:0] left_d;
	logic [7:0] sum_d;
	logic [7:0] len;
	logic [7:0] cmd_sum;
	logic [7:0] par_sum;
	logic       accept;

	assign cfg.ready  = 1'b1;
	assign item.ready = push_ready;
	assign push_valid = item.valid;
	assign accept     = item.valid & push_ready;

	assign len     = {3'b000, item.param_count} + 8'd3;
	assign cmd_sum = item.device_id + len + item.instruction_code + item.register_address;
	assign par_sum = sum_q + item.param_byte;

	always_comb begin
		push_job           = '0;
		push_job.jtype     = JOB_ERR;
		push_job.status    = ST_ORDER;
		push_job.hdr       = hdr_q;
		awaiting_d         = awaiting_q;
		left_d             = left_q;
		sum_d              = sum_q;
		if (item.kind == KIND_CMD) begin
			if (awaiting_q) begin
				// abandon the open frame
				awaiting_d = 1'b0;
				left_d     = '0;
				sum_d      = '0;
			end else if (item.param_count > 5'(MAX_PARAMS)) begin
				push_job.status = ST_OVER;
			end else begin
				push_job.jtype  = JOB_CMD;
				push_job.status = ST_OK;
				push_job.b0     = item.device_id;
				push_job.b1     = len;
				push_job.b2     = item.instruction_code;
				push_job.b3     = item.register_address;
				push_job.csum   = ~cmd_sum;
				if (item.param_count == '0) begin
					push_job.with_csum = 1'b1;
				end else begin
					awaiting_d = 1'b1;
					left_d     = item.param_count;
					sum_d      = cmd_sum;
				end
			end
		end else if (awaiting_q && left_q != '0) begin
			push_job.jtype  = JOB_PARAM;
			push_job.status = ST_OK;
			push_job.b0     = item.param_byte;
			push_job.csum   = ~par_sum;
			left_d          = left_q - 5'd1;
			sum_d           = par_sum;
			if (left_q == 5'd1) begin
				push_job.with_csum = 1'b1;
				awaiting_d         = 1'b0;
				sum_d              = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			left_q     <= '0;
			sum_q      <= '0;
			hdr_q      <= 8'hFF;
		end else begin
			if (cfg.valid) begin
				hdr_q <= cfg.header_byte;
			end
			if (accept) begin
				awaiting_q <= awaiting_d;
				left_q     <= left_d;
				sum_q      <= sum_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scfr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfr_queue
	import scfr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	input  wire job_t   push_job,
	output logic        push_ready,
	output logic        pop_valid,
	output job_t        pop_job,
	input  wire logic   pop_ready
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scfr_back
	import scfr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   pop_valid,
	input  wire job_t   pop_job,
	output logic        pop_ready,
	scfr_byte_if.source frame
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;
	status_t    out_status_q;

	logic [7:0] byte_d;
	logic       end_d;
	status_t    status_d;
	logic       last;
	logic       load;

	assign load      = !out_valid_q || frame.ready;
	assign pop_ready = pop_valid & load & last;

	assign frame.valid     = out_valid_q;
	assign frame.out_byte  = out_byte_q;
	assign frame.frame_end = out_end_q;
	assign frame.status    = out_status_q;

	// Pick the byte at the current position of the job at the queue head
	always_comb begin
		byte_d   = '0;
		end_d    = 1'b0;
		status_d = ST_OK;
		last     = 1'b1;
		unique case (pop_job.jtype)
			JOB_CMD: begin
				last = pop_job.with_csum ? (idx_q == IDX_CSUM) : (idx_q == IDX_ADDR);
				unique case (idx_q)
					IDX_HDR0, IDX_HDR1: byte_d = pop_job.hdr;
					IDX_ID:             byte_d = pop_job.b0;
					IDX_LEN:            byte_d = pop_job.b1;
					IDX_INS:            byte_d = pop_job.b2;
					IDX_ADDR:           byte_d = pop_job.b3;
					default: begin
						byte_d = pop_job.csum;
						end_d  = 1'b1;
					end
				endcase
			end
			JOB_PARAM: begin
				if (idx_q == IDX_HDR0) begin
					byte_d = pop_job.b0;
					last   = !pop_job.with_csum;
				end else begin
					byte_d = pop_job.csum;
					end_d  = 1'b1;
				end
			end
			default: begin
				end_d    = 1'b1;
				status_d = pop_job.status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			out_byte_q   <= byte_d;
			out_end_q    <= end_d;
			out_status_q <= status_d;
		end
	end

	// Job stays at the queue head until its last byte is loaded
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> pop_valid)
		else $error("byte position advanced with no job at the queue head");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_end_q && out_byte_q == 8'd0)
		else $error("error transaction without frame end or with nonzero byte");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_CSUM)
		else $error("byte position beyond checksum");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready |=> idx_q == 3'd0)
		else $error("byte position not rewound after job completed");

endmodule

`default_nettype wire

// ----- hw/rtl/servo_command_packet_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Servo command frame builder.
// item  : command items (kind 0) open a frame, parameter items (kind 1) add bytes.
// frame : byte stream out; frame_end marks the checksum byte or an error transaction,
//         status gives 0 ok, 1 count over limit, 2 item out of order.
// cfg   : write-only header byte, always ready; write it only while the block is idle.
// A command yields header, header, id, length, instruction, address (six bytes), plus
// the checksum when it announces no parameters. A parameter yields its byte, plus the
// checksum after the last one. Errors yield one byte 0 with frame_end set.
// The front classifies one item per cycle into a four-entry job queue; the back end
// expands jobs into one byte per cycle through a registered output stage. With the queue
// empty, the first byte of an item is written into the queue and then loaded into the
// output register before it is valid on frame. The output port sustains one byte per
// cycle while frame is ready; item takes one transaction per cycle until the queue
// fills, which a command (six or seven output bytes) does when items keep coming.
// A stall on frame holds the output byte and backs up into the queue, then into item.
// Reset empties the queue and output stage, closes any open frame and sets the header
// byte to 0xFF.
module servo_command_packet_framer
	import scfr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	scfr_item_if.sink   item,
	scfr_cfg_if.sink    cfg,
	scfr_byte_if.source frame
);

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	scfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	scfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	scfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.frame     (frame)
	);

endmodule

`default_nettype wire
